FILE: sv/imuacc_pkg.sv
// Shared types and constants for the inertial sample accumulator.
// No dependencies; used by imuacc_sum_bank and imu_sample_accumulator_top.
package imuacc_pkg;

	localparam int NumCh    = 7;
	localparam int SumW     = 32;
	localparam int CountW   = 16;
	localparam int WordW    = 16;
	localparam int NegW     = 3;
	localparam int CfgIdxW  = 2;

	localparam int ChGx = 0;
	localparam int ChGy = 1;
	localparam int ChGz = 2;
	localparam int ChAx = 3;
	localparam int ChAy = 4;
	localparam int ChAz = 5;
	localparam int ChT  = 6;

	localparam logic [CfgIdxW-1:0] CfgGyroNegate  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgAccelNegate = 2'd1;
	localparam logic [NegW-1:0]    NegateReset    = 3'd4;
	localparam logic [CountW-1:0]  CountMax       = 16'hFFFF;

	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_READ  = 1'b1
	} imuacc_op_t;

	typedef logic [NumCh-1:0][SumW-1:0] imuacc_sums_t;

	typedef struct packed {
		logic acc;
		logic rd;
	} imuacc_ctl_t;

	function automatic logic [SumW-1:0] be_word(input logic [WordW-1:0] w);
		return {{(SumW-WordW){w[WordW-1]}}, w};
	endfunction

	function automatic logic [SumW-1:0] le_word_shifted(input logic [WordW-1:0] w);
		logic [WordW-1:0] v;
		v = {w[7:0], w[15:8]};
		return {{(SumW-WordW+2){v[WordW-1]}}, v[WordW-1:2]};
	endfunction

endpackage

FILE: sv/imuacc_sum_bank.sv
// Running channel sums and sample count for the inertial sample accumulator.
// Depends on imuacc_pkg.
module imuacc_sum_bank (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  imuacc_pkg::imuacc_ctl_t                 ctl,
	input  imuacc_pkg::imuacc_sums_t                addend,
	output imuacc_pkg::imuacc_sums_t                sums,
	output logic [imuacc_pkg::CountW-1:0]           count
);

	imuacc_pkg::imuacc_sums_t              sums_q;
	logic [imuacc_pkg::CountW-1:0]         count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q  <= '0;
			count_q <= '0;
		end else if (ctl.rd) begin
			sums_q  <= '0;
			count_q <= '0;
		end else if (ctl.acc) begin
			count_q <= count_q + 1'b1;
			if (count_q == imuacc_pkg::CountMax) begin
				sums_q <= '0;
			end else begin
				for (int i = 0; i < imuacc_pkg::NumCh; i++) begin
					sums_q[i] <= sums_q[i] + addend[i];
				end
			end
		end
	end

	assign sums  = sums_q;
	assign count = count_q;

endmodule

FILE: sv/imu_sample_accumulator_top.sv
// Top level of the inertial sample accumulator: input stage, word decode,
// negation and result register. Depends on imuacc_pkg and imuacc_sum_bank.
//
// Usage: each input word carries an operation and one raw sensor burst.
// An accumulate word decodes the burst (gyro and temperature big-endian,
// accelerometer little-endian shifted right by two) and adds it into seven
// 32-bit sums; it yields no result. A read word yields one result word with
// the axis sums (negated per the negate registers), the temperature sum and
// the sample count, then clears sums and count. When the count wraps, the
// sums are cleared.
// Result path: a read word passes the input stage register, then the output
// register; while a result is stalled, the next read waits in the input stage.
// Throughput: one word per cycle while in_stall is low; a blocked read stalls it.
// Stall: while the receiver stalls, the result holds and one more read word
// may wait in the input stage; accumulate words keep flowing until that
// read word arrives, then the input stalls until the result is taken.
// Reset clears sums, count, valids and sets both negate registers to 4.
// Configuration: cfg_ready is always high; write only while idle.
module imu_sample_accumulator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [imuacc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [imuacc_pkg::NegW-1:0]          cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [15:0]                          temp_bytes,
	input  logic [15:0]                          gyro_pair_a,
	input  logic [15:0]                          gyro_pair_b,
	input  logic [15:0]                          gyro_pair_c,
	input  logic [15:0]                          accel_pair_a,
	input  logic [15:0]                          accel_pair_b,
	input  logic [15:0]                          accel_pair_c,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [31:0]                   gyro_x_total,
	output logic signed [31:0]                   gyro_y_total,
	output logic signed [31:0]                   gyro_z_total,
	output logic signed [31:0]                   accel_x_total,
	output logic signed [31:0]                   accel_y_total,
	output logic signed [31:0]                   accel_z_total,
	output logic signed [31:0]                   temp_total,
	output logic [15:0]                          sample_total
);

	logic [imuacc_pkg::NegW-1:0] gyro_neg_q;
	logic [imuacc_pkg::NegW-1:0] accel_neg_q;

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] temp_s1, gya_s1, gyb_s1, gyc_s1, aca_s1, acb_s1, acc_s1;

	logic                          out_valid_q;
	imuacc_pkg::imuacc_sums_t      res_q;
	logic [imuacc_pkg::CountW-1:0] res_count_q;

	logic                          accept;
	logic                          adv_s1;
	imuacc_pkg::imuacc_ctl_t       ctl;
	imuacc_pkg::imuacc_sums_t      addend;
	imuacc_pkg::imuacc_sums_t      sums;
	imuacc_pkg::imuacc_sums_t      neg_sums;
	logic [imuacc_pkg::CountW-1:0] count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_neg_q  <= imuacc_pkg::NegateReset;
			accel_neg_q <= imuacc_pkg::NegateReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				imuacc_pkg::CfgGyroNegate:  gyro_neg_q  <= cfg_data;
				imuacc_pkg::CfgAccelNegate: accel_neg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (op_s1 == imuacc_pkg::OP_ACCUM || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			temp_s1 <= temp_bytes;
			gya_s1  <= gyro_pair_a;
			gyb_s1  <= gyro_pair_b;
			gyc_s1  <= gyro_pair_c;
			aca_s1  <= accel_pair_a;
			acb_s1  <= accel_pair_b;
			acc_s1  <= accel_pair_c;
		end
	end

	assign ctl.acc = adv_s1 && op_s1 == imuacc_pkg::OP_ACCUM;
	assign ctl.rd  = adv_s1 && op_s1 == imuacc_pkg::OP_READ;

	always_comb begin
		addend                  = '0;
		addend[imuacc_pkg::ChT]  = imuacc_pkg::be_word(temp_s1);
		addend[imuacc_pkg::ChGy] = imuacc_pkg::be_word(gya_s1);
		addend[imuacc_pkg::ChGx] = imuacc_pkg::be_word(gyb_s1);
		addend[imuacc_pkg::ChGz] = imuacc_pkg::be_word(gyc_s1);
		addend[imuacc_pkg::ChAy] = imuacc_pkg::le_word_shifted(aca_s1);
		addend[imuacc_pkg::ChAx] = imuacc_pkg::le_word_shifted(acb_s1);
		addend[imuacc_pkg::ChAz] = imuacc_pkg::le_word_shifted(acc_s1);
	end

	imuacc_sum_bank u_sum_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addend (addend),
		.sums   (sums),
		.count  (count)
	);

	always_comb begin
		neg_sums = sums;
		for (int i = 0; i < imuacc_pkg::NegW; i++) begin
			if (gyro_neg_q[i]) begin
				neg_sums[imuacc_pkg::ChGx + i] = '0 - sums[imuacc_pkg::ChGx + i];
			end
			if (accel_neg_q[i]) begin
				neg_sums[imuacc_pkg::ChAx + i] = '0 - sums[imuacc_pkg::ChAx + i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.rd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			res_q       <= neg_sums;
			res_count_q <= count;
		end
	end

	assign out_valid     = out_valid_q;
	assign gyro_x_total  = res_q[imuacc_pkg::ChGx];
	assign gyro_y_total  = res_q[imuacc_pkg::ChGy];
	assign gyro_z_total  = res_q[imuacc_pkg::ChGz];
	assign accel_x_total = res_q[imuacc_pkg::ChAx];
	assign accel_y_total = res_q[imuacc_pkg::ChAy];
	assign accel_z_total = res_q[imuacc_pkg::ChAz];
	assign temp_total    = res_q[imuacc_pkg::ChT];
	assign sample_total  = res_count_q;

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |=> out_valid && count == '0 && sums == '0)
		else $error("read did not clear sums or raise the result");

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc && count == imuacc_pkg::CountMax |=> count == '0 && sums == '0)
		else $error("count wrap did not clear sums");

	a_stall_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && op_s1 == imuacc_pkg::OP_READ && out_valid && out_stall)
		else $error("input stalled without a blocked read");

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !ctl.rd)
		else $error("result overwritten while stalled");

endmodule
